### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define RAST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define RAST_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/rast_pkg.sv
// ----------------------------------------------------------------------------
// rast_pkg
// Types and constants shared by the remote address slot table.
// ----------------------------------------------------------------------------
package rast_pkg;

    // Default sizes
    localparam int DEF_SLOTS     = 8;
    localparam int DEF_LOCAL_IDS = 8;

    // Fixed field widths
    localparam int MODE_W  = 2;
    localparam int ID_W    = 8;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int SLOTF_W = 3;

    // Request kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_MARK   = 2'd2
    } t_mode;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_DONE
    } t_state;

    // Write strobes towards the slot store
    typedef struct packed {
        logic ent;   // id, address and port
        logic mask;  // tried-locals mask
    } t_store_wr;

    // One finished answer
    typedef struct packed {
        logic               refused;
        logic [SLOTF_W-1:0] slot;
        logic               list_changed;
    } t_result;

endpackage

### src/rast_store.sv
// ----------------------------------------------------------------------------
// rast_store
// Slot payload memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rast_store import rast_pkg::*; #(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int LOCAL_IDS = DEF_LOCAL_IDS,
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 i_clk,
    input  t_store_wr            i_wr,
    input  logic [SLOT_W-1:0]    i_wr_idx,
    input  logic [ID_W-1:0]      i_wr_ident,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [PORT_W-1:0]    i_wr_port,
    input  logic [LOCAL_IDS-1:0] i_wr_mask,
    input  logic [SLOT_W-1:0]    i_rd_idx,
    output logic [ID_W-1:0]      o_rd_ident,
    output logic [ADDR_W-1:0]    o_rd_addr,
    output logic [PORT_W-1:0]    o_rd_port,
    output logic [LOCAL_IDS-1:0] o_rd_mask
);

    logic [ID_W-1:0]      r_ident [SLOTS];
    logic [ADDR_W-1:0]    r_addr  [SLOTS];
    logic [PORT_W-1:0]    r_port  [SLOTS];
    logic [LOCAL_IDS-1:0] r_mask  [SLOTS];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.ent) begin
            r_ident[i_wr_idx] <= i_wr_ident;
            r_addr[i_wr_idx]  <= i_wr_addr;
            r_port[i_wr_idx]  <= i_wr_port;
        end
        if (i_wr.mask) begin
            r_mask[i_wr_idx] <= i_wr_mask;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_ident <= r_ident[i_rd_idx];
        o_rd_addr  <= r_addr[i_rd_idx];
        o_rd_port  <= r_port[i_rd_idx];
        o_rd_mask  <= r_mask[i_rd_idx];
    end

endmodule

### src/rast_seq.sv
// ----------------------------------------------------------------------------
// rast_seq
// Scan sequencer: one slot compared per cycle, valid bits and list flag.
// ----------------------------------------------------------------------------
module rast_seq import rast_pkg::*; #(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int LOCAL_IDS = DEF_LOCAL_IDS,
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request
    input  logic                 i_start,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [ID_W-1:0]      i_peer_id,
    input  logic [ADDR_W-1:0]    i_peer_addr,
    input  logic [PORT_W-1:0]    i_peer_port,
    output logic                 o_idle,
    // answer
    output logic                 o_done,
    output t_result              o_result,
    input  logic                 i_take,
    // store
    output t_store_wr            o_wr,
    output logic [SLOT_W-1:0]    o_wr_idx,
    output logic [ID_W-1:0]      o_wr_ident,
    output logic [ADDR_W-1:0]    o_wr_addr,
    output logic [PORT_W-1:0]    o_wr_port,
    output logic [LOCAL_IDS-1:0] o_wr_mask,
    output logic [SLOT_W-1:0]    o_rd_idx,
    input  logic [ID_W-1:0]      i_rd_ident,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    input  logic [PORT_W-1:0]    i_rd_port,
    input  logic [LOCAL_IDS-1:0] i_rd_mask
);

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [ID_W-1:0]     r_id, n_id;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [PORT_W-1:0]   r_port, n_port;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic                r_list, n_list;
    logic                r_refused, n_refused;
    logic [SLOT_W-1:0]   r_hit, n_hit;
    logic                r_free_found, n_free_found;
    logic [SLOT_W-1:0]   r_free_idx, n_free_idx;

    logic                cur_valid;
    logic                id_eq;
    logic                addr_eq;
    logic                port_eq;
    logic                last;
    logic [LOCAL_IDS-1:0] mark_bit;

    // Shared compare against the slot just read
    assign cur_valid = r_valid[r_idx];
    assign id_eq     = (i_rd_ident == r_id);
    assign addr_eq   = (i_rd_addr == r_addr);
    assign port_eq   = (i_rd_port == r_port);
    assign last      = (r_idx == SLOT_W'(SLOTS - 1));
    // out-of-range ids shift the bit off the top: nothing set
    assign mark_bit  = LOCAL_IDS'(1) << r_id;

    // Store side id, address and port always come from the held request
    assign o_wr_ident = r_id;
    assign o_wr_addr  = r_addr;
    assign o_wr_port  = r_port;
    assign o_wr_mask  = (r_state == ST_FILL) ? '0 : (i_rd_mask | mark_bit);
    assign o_wr_idx   = (r_state == ST_FILL) ? r_free_idx : r_idx;
    assign o_rd_idx   = n_idx;

    assign o_idle                = (r_state == ST_IDLE);
    assign o_done                = (r_state == ST_DONE);
    assign o_result.refused      = r_refused;
    assign o_result.slot         = r_refused ? '0 : SLOTF_W'(r_hit);
    assign o_result.list_changed = r_list;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_list  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_list  <= n_list;
        end
    end

    // Request and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_mode       <= n_mode;
        r_id         <= n_id;
        r_addr       <= n_addr;
        r_port       <= n_port;
        r_refused    <= n_refused;
        r_hit        <= n_hit;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
    end

    // Next state and store strobes
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_mode       = r_mode;
        n_id         = r_id;
        n_addr       = r_addr;
        n_port       = r_port;
        n_valid      = r_valid;
        n_list       = r_list;
        n_refused    = r_refused;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        o_wr         = '0;

        case (r_state)
            ST_IDLE: begin
                n_idx        = '0;
                n_free_found = 1'b0;
                n_free_idx   = '0;
                n_hit        = '0;
                n_refused    = 1'b0;
                if (i_start) begin
                    n_mode = i_mode;
                    n_id   = i_peer_id;
                    n_addr = i_peer_addr;
                    n_port = i_peer_port;
                    if (i_mode inside {MODE_ADD, MODE_REMOVE, MODE_MARK}) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_refused = 1'b1;
                        n_state   = ST_DONE;
                    end
                end
            end

            ST_SCAN: begin
                n_idx = r_idx + SLOT_W'(1);
                case (r_mode)
                    MODE_ADD: begin
                        if (cur_valid && id_eq && addr_eq && port_eq) begin
                            // exact entry already present
                            n_hit   = r_idx;
                            n_state = ST_DONE;
                        end else if (cur_valid && id_eq && !addr_eq) begin
                            // same id, new address: overwrite
                            o_wr.ent = 1'b1;
                            n_list   = 1'b1;
                            n_hit    = r_idx;
                            n_state  = ST_DONE;
                        end else begin
                            if (!cur_valid && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_idx;
                            end
                            if (last) begin
                                n_state = ST_FILL;
                            end
                        end
                    end
                    MODE_REMOVE: begin
                        if (cur_valid && id_eq) begin
                            n_valid[r_idx] = 1'b0;
                            n_hit          = r_idx;
                            n_state        = ST_DONE;
                        end else if (last) begin
                            n_refused = 1'b1;
                            n_state   = ST_DONE;
                        end
                    end
                    MODE_MARK: begin
                        if (cur_valid && addr_eq) begin
                            o_wr.mask = 1'b1;
                            n_hit     = r_idx;
                            n_state   = ST_DONE;
                        end else if (last) begin
                            n_refused = 1'b1;
                            n_state   = ST_DONE;
                        end
                    end
                    default: begin
                        n_refused = 1'b1;
                        n_state   = ST_DONE;
                    end
                endcase
            end

            // Fill the lowest free slot, or refuse when full
            ST_FILL: begin
                if (r_free_found) begin
                    o_wr.ent            = 1'b1;
                    o_wr.mask           = 1'b1;
                    n_valid[r_free_idx] = 1'b1;
                    n_list              = 1'b1;
                    n_hit               = r_free_idx;
                end else begin
                    n_refused = 1'b1;
                end
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### src/remote_address_slot_table_top.sv
// ----------------------------------------------------------------------------
// remote_address_slot_table_top
// Remote endpoint slot table: add/update, remove by id, mark local-id bit.
// ----------------------------------------------------------------------------
//  channel   dir  transfer when              payload
//  s_axis    in   i_s_axis_tvalid & ready    tuser: mode; tdata: id, addr, port
//  m_axis    out  o_m_axis_tvalid & tready   tdata: status, slot, list_changed
//
//  A request with the unused mode is refused without a scan; a scan reads
//  one slot a cycle through the store's single registered read port, and an
//  add that finds no match then passes through the fill state.
//  The next request is taken once the answer sits in the output register.
//  Reset (synchronous, active low) clears valid bits, the list flag and the
//  output valid and idles the sequencer; slot payload is written before use.
//  A stalled output holds the answer; the sequencer waits until it can load.
// ----------------------------------------------------------------------------
module remote_address_slot_table_top import rast_pkg::*; #(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int LOCAL_IDS = DEF_LOCAL_IDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // peer_id[7:0], peer_addr[39:8], peer_port[55:40]
    input  logic [1:0]  i_s_axis_tuser,  // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata   // status[0], slot[3:1], list_changed[4], zero[7:5]
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic                 start;
    logic                 seq_idle;
    logic                 seq_done;
    logic                 take;
    t_result              seq_result;
    t_store_wr            st_wr;
    logic [SLOT_W-1:0]    st_wr_idx;
    logic [SLOT_W-1:0]    st_rd_idx;
    logic [ID_W-1:0]      wr_ident, rd_ident;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [PORT_W-1:0]    wr_port, rd_port;
    logic [LOCAL_IDS-1:0] wr_mask, rd_mask;

    logic                 r_out_valid;
    logic [7:0]           r_out_data;

    // Input transfer
    assign o_s_axis_tready = seq_idle;
    assign start           = i_s_axis_tvalid && seq_idle;

    // Answer moves into the output register when it is free or being drained
    assign take = seq_done && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= {3'b000, seq_result.list_changed, seq_result.slot,
                           seq_result.refused};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    rast_seq #(
        .SLOTS     (SLOTS),
        .LOCAL_IDS (LOCAL_IDS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_s_axis_tuser),
        .i_peer_id   (i_s_axis_tdata[7:0]),
        .i_peer_addr (i_s_axis_tdata[39:8]),
        .i_peer_port (i_s_axis_tdata[55:40]),
        .o_idle      (seq_idle),
        .o_done      (seq_done),
        .o_result    (seq_result),
        .i_take      (take),
        .o_wr        (st_wr),
        .o_wr_idx    (st_wr_idx),
        .o_wr_ident  (wr_ident),
        .o_wr_addr   (wr_addr),
        .o_wr_port   (wr_port),
        .o_wr_mask   (wr_mask),
        .o_rd_idx    (st_rd_idx),
        .i_rd_ident  (rd_ident),
        .i_rd_addr   (rd_addr),
        .i_rd_port   (rd_port),
        .i_rd_mask   (rd_mask)
    );

    rast_store #(
        .SLOTS     (SLOTS),
        .LOCAL_IDS (LOCAL_IDS)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr       (st_wr),
        .i_wr_idx   (st_wr_idx),
        .i_wr_ident (wr_ident),
        .i_wr_addr  (wr_addr),
        .i_wr_port  (wr_port),
        .i_wr_mask  (wr_mask),
        .i_rd_idx   (st_rd_idx),
        .o_rd_ident (rd_ident),
        .o_rd_addr  (rd_addr),
        .o_rd_port  (rd_port),
        .o_rd_mask  (rd_mask)
    );

endmodule

### src/rast_checker.sv
// ----------------------------------------------------------------------------
// rast_checker
// Port-level checks on the slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rast_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);

    logic       r_seen_changed;
    logic       in_xfer;
    logic       out_stall;
    logic       out_refused;
    logic [2:0] out_slot;
    logic       out_changed;

    // Short names for the handshakes and the answer fields
    assign in_xfer     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_refused = o_m_axis_tdata[0];
    assign out_slot    = o_m_axis_tdata[3:1];
    assign out_changed = o_m_axis_tdata[4];

    // List flag once reported set must stay set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_changed <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready && out_changed) begin
            r_seen_changed <= 1'b1;
        end
    end

    `RAST_ASSERT_RST(a_rst_out_idle, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")
    `RAST_ASSERT(a_refused_slot, o_m_axis_tvalid && out_refused |-> out_slot == 3'd0, "slot set")
    `RAST_ASSERT(a_list_sticky, o_m_axis_tvalid && r_seen_changed |-> out_changed, "flag dropped")
    `RAST_ASSERT(a_busy_after_in, in_xfer |=> !o_s_axis_tready, "ready while busy")
    `RAST_ASSERT(a_out_hold, out_stall |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "held")

endmodule

bind remote_address_slot_table_top rast_checker u_rast_checker (.*);
